### rtl/core/pe_pkg.sv
// Package with shared types, constants and helper functions for the particle Euler update.
package pe_pkg;

  // Default number of color gradient steps.
  localparam int unsigned GRADIENT_STEPS_DEF = 100;

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Width of a Q16.16 sum before saturation: 48 bits of floored product plus sign growth.
  localparam int unsigned SUM_W = 49;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRICTION  = 2'd0,
    CFG_GRAVITY_X = 2'd1,
    CFG_GRAVITY_Y = 2'd2,
    CFG_MAX_AGE   = 2'd3
  } cfg_idx_e;

  // Reset values of the configuration registers.
  localparam logic [30:0]        FRICTION_RST  = 31'd65536;
  localparam logic signed [31:0] GRAVITY_X_RST = 32'sh0000_0000;
  localparam logic signed [31:0] GRAVITY_Y_RST = 32'shFFFF_0000;
  localparam logic [30:0]        MAX_AGE_RST   = 31'd655360;

  // One particle record as it comes in.
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [30:0]        age_in;
    logic [3:0]         pair_in;
    logic               alive_in;
    logic [30:0]        time_step;
  } pe_in_t;

  // One updated particle record.
  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic [30:0]        new_age;
    logic [3:0]         pair_out;
    logic               alive_out;
    logic               draw_now;
    logic [6:0]         gradient_step;
  } pe_out_t;

  // Configuration register contents.
  typedef struct packed {
    logic [30:0]        friction_factor;
    logic signed [31:0] gravity_x;
    logic signed [31:0] gravity_y;
    logic [30:0]        max_age;
  } pe_cfg_t;

  // Motion part of a result.
  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic [3:0]         pair_out;
  } pe_kin_t;

  // Age and drawing part of a result.
  typedef struct packed {
    logic [30:0] new_age;
    logic        alive_out;
    logic        draw_now;
    logic [6:0]  gradient_step;
  } pe_age_t;

  // Clamp a wide signed sum to the 32-bit signed range.
  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
    logic same;
    same = (v[SUM_W-1:31] == '0) || (v[SUM_W-1:31] == '1);
    if (same) begin
      return v[31:0];
    end else if (v[SUM_W-1]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7FFF_FFFF;
    end
  endfunction

endpackage

### rtl/core/pe_cfg_regs.sv
// Configuration register file of the particle Euler update.
module pe_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pe_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pe_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output pe_pkg::pe_cfg_t                 cfg_o
);

  pe_pkg::pe_cfg_t cfg_q;

  // Each write lands in the register selected by the index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.friction_factor <= pe_pkg::FRICTION_RST;
      cfg_q.gravity_x       <= pe_pkg::GRAVITY_X_RST;
      cfg_q.gravity_y       <= pe_pkg::GRAVITY_Y_RST;
      cfg_q.max_age         <= pe_pkg::MAX_AGE_RST;
    end else if (cfg_we_i) begin
      case (pe_pkg::cfg_idx_e'(cfg_idx_i))
        pe_pkg::CFG_FRICTION:  cfg_q.friction_factor <= cfg_wdata_i[30:0];
        pe_pkg::CFG_GRAVITY_X: cfg_q.gravity_x       <= cfg_wdata_i;
        pe_pkg::CFG_GRAVITY_Y: cfg_q.gravity_y       <= cfg_wdata_i;
        pe_pkg::CFG_MAX_AGE:   cfg_q.max_age         <= cfg_wdata_i[30:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/core/pe_kinematics.sv
// Four-stage velocity and position pipeline with an alignment delay line behind it.
module pe_kinematics #(
  parameter int unsigned EXTRA = 5
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  pe_pkg::pe_in_t  in_i,
  input  pe_pkg::pe_cfg_t cfg_i,
  output logic            valid_o,
  output pe_pkg::pe_kin_t kin_o
);

  // Stage 1: velocity times friction.
  logic                      v1_q;
  logic signed [63:0]        prodx_q, prody_q;
  logic signed [31:0]        posx1_q, posy1_q, velx1_q, vely1_q;
  logic [30:0]               dt1_q;
  logic                      alive1_q;
  logic [3:0]                pair1_q;
  logic signed [63:0]        prodx_d, prody_d;
  logic signed [31:0]        fric_s;

  assign fric_s  = $signed({1'b0, cfg_i.friction_factor});
  assign prodx_d = 64'(in_i.vel_x) * 64'(fric_s);
  assign prody_d = 64'(in_i.vel_y) * 64'(fric_s);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      prodx_q  <= prodx_d;
      prody_q  <= prody_d;
      posx1_q  <= in_i.pos_x;
      posy1_q  <= in_i.pos_y;
      velx1_q  <= in_i.vel_x;
      vely1_q  <= in_i.vel_y;
      dt1_q    <= in_i.time_step;
      alive1_q <= in_i.alive_in;
      pair1_q  <= in_i.pair_in;
    end
  end

  // Stage 2: floor to Q16.16, add gravity and saturate.
  logic                      v2_q;
  logic signed [31:0]        velx2_q, vely2_q, posx2_q, posy2_q;
  logic [30:0]               dt2_q;
  logic                      alive2_q;
  logic [3:0]                pair2_q;
  logic signed [pe_pkg::SUM_W-1:0] sumx_d, sumy_d;
  logic signed [31:0]        velx2_d, vely2_d;

  assign sumx_d = {prodx_q[63], prodx_q[63:16]}
                + {{(pe_pkg::SUM_W-32){cfg_i.gravity_x[31]}}, cfg_i.gravity_x};
  assign sumy_d = {prody_q[63], prody_q[63:16]}
                + {{(pe_pkg::SUM_W-32){cfg_i.gravity_y[31]}}, cfg_i.gravity_y};
  assign velx2_d = alive1_q ? pe_pkg::sat32(sumx_d) : velx1_q;
  assign vely2_d = alive1_q ? pe_pkg::sat32(sumy_d) : vely1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      velx2_q  <= velx2_d;
      vely2_q  <= vely2_d;
      posx2_q  <= posx1_q;
      posy2_q  <= posy1_q;
      dt2_q    <= dt1_q;
      alive2_q <= alive1_q;
      pair2_q  <= pair1_q;
    end
  end

  // Stage 3: new velocity times the time step.
  logic                      v3_q;
  logic signed [63:0]        dpx_q, dpy_q, dpx_d, dpy_d;
  logic signed [31:0]        velx3_q, vely3_q, posx3_q, posy3_q;
  logic                      alive3_q;
  logic [3:0]                pair3_q;
  logic signed [31:0]        dt_s;

  assign dt_s  = $signed({1'b0, dt2_q});
  assign dpx_d = 64'(velx2_q) * 64'(dt_s);
  assign dpy_d = 64'(vely2_q) * 64'(dt_s);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      dpx_q    <= dpx_d;
      dpy_q    <= dpy_d;
      velx3_q  <= velx2_q;
      vely3_q  <= vely2_q;
      posx3_q  <= posx2_q;
      posy3_q  <= posy2_q;
      alive3_q <= alive2_q;
      pair3_q  <= pair2_q;
    end
  end

  // Stage 4: advance the position and saturate.
  logic                      v4_q;
  pe_pkg::pe_kin_t           kin4_q, kin4_d;
  logic signed [pe_pkg::SUM_W-1:0] npx_d, npy_d;

  assign npx_d = {{(pe_pkg::SUM_W-32){posx3_q[31]}}, posx3_q} + {dpx_q[63], dpx_q[63:16]};
  assign npy_d = {{(pe_pkg::SUM_W-32){posy3_q[31]}}, posy3_q} + {dpy_q[63], dpy_q[63:16]};

  always_comb begin
    kin4_d.new_pos_x = alive3_q ? pe_pkg::sat32(npx_d) : posx3_q;
    kin4_d.new_pos_y = alive3_q ? pe_pkg::sat32(npy_d) : posy3_q;
    kin4_d.new_vel_x = velx3_q;
    kin4_d.new_vel_y = vely3_q;
    kin4_d.pair_out  = pair3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v3_q) begin
      kin4_q <= kin4_d;
    end
  end

  // Delay line that lines the motion fields up with the gradient divider.
  if (EXTRA > 0) begin : g_dly
    pe_pkg::pe_kin_t  dly_q [EXTRA];
    logic [EXTRA-1:0] dv_q;

    for (genvar i = 0; i < EXTRA; i++) begin : g_tap
      logic            v_in;
      pe_pkg::pe_kin_t k_in;

      if (i == 0) begin : g_first
        assign v_in = v4_q;
        assign k_in = kin4_q;
      end else begin : g_next
        assign v_in = dv_q[i-1];
        assign k_in = dly_q[i-1];
      end

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          dv_q[i] <= 1'b0;
        end else begin
          dv_q[i] <= v_in;
        end
      end

      always_ff @(posedge clk_i) begin
        if (v_in) begin
          dly_q[i] <= k_in;
        end
      end
    end

    assign valid_o = dv_q[EXTRA-1];
    assign kin_o   = dly_q[EXTRA-1];
  end else begin : g_nodly
    assign valid_o = v4_q;
    assign kin_o   = kin4_q;
  end

endmodule

### rtl/core/pe_age_div.sv
// Age update and pipelined restoring divider for the gradient step, one quotient bit per stage.
module pe_age_div #(
  parameter int unsigned GRADIENT_STEPS = pe_pkg::GRADIENT_STEPS_DEF,
  parameter int unsigned QS             = 7
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  pe_pkg::pe_in_t  in_i,
  input  pe_pkg::pe_cfg_t cfg_i,
  output logic            valid_o,
  output pe_pkg::pe_age_t age_o
);

  localparam int unsigned NW = 31 + QS;

  // Stage 1: age plus step, saturated to 31 bits.
  logic        v1_q;
  logic [30:0] age1_q, age1_d;
  logic        alive1_q;
  logic [31:0] age_sum;

  assign age_sum = {1'b0, in_i.age_in} + {1'b0, in_i.time_step};

  always_comb begin
    if (!in_i.alive_in) begin
      age1_d = in_i.age_in;
    end else if (age_sum[31]) begin
      age1_d = '1;
    end else begin
      age1_d = age_sum[30:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      age1_q   <= age1_d;
      alive1_q <= in_i.alive_in;
    end
  end

  // Stage 2: death check and scaled dividend.
  logic          v2_q;
  logic [30:0]   age2_q, den2_q;
  logic          draw2_q, zmax2_q;
  logic [NW-1:0] num2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      age2_q  <= age1_q;
      den2_q  <= cfg_i.max_age;
      draw2_q <= alive1_q && (age1_q <= cfg_i.max_age);
      zmax2_q <= (cfg_i.max_age == '0);
      num2_q  <= NW'(age1_q) * NW'(GRADIENT_STEPS);
    end
  end

  // Divider stages, most significant quotient bit first.
  logic [QS-1:0] dv_q;
  logic [NW-1:0] rem_q   [QS];
  logic [QS-1:0] quo_q   [QS];
  logic [30:0]   den_q   [QS];
  logic [30:0]   age_q   [QS];
  logic [QS-1:0] draw_q;
  logic [QS-1:0] zmax_q;

  for (genvar s = 0; s < QS; s++) begin : g_div
    logic          v_in;
    logic [NW-1:0] rem_in, den_sh;
    logic [QS-1:0] quo_in;
    logic [30:0]   den_in, age_in;
    logic          draw_in, zmax_in, take;

    if (s == 0) begin : g_first
      assign v_in    = v2_q;
      assign rem_in  = num2_q;
      assign quo_in  = '0;
      assign den_in  = den2_q;
      assign age_in  = age2_q;
      assign draw_in = draw2_q;
      assign zmax_in = zmax2_q;
    end else begin : g_next
      assign v_in    = dv_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign den_in  = den_q[s-1];
      assign age_in  = age_q[s-1];
      assign draw_in = draw_q[s-1];
      assign zmax_in = zmax_q[s-1];
    end

    assign den_sh = NW'(den_in) << (QS - 1 - s);
    assign take   = (rem_in >= den_sh);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[s] <= 1'b0;
      end else begin
        dv_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (v_in) begin
        rem_q[s]  <= take ? (rem_in - den_sh) : rem_in;
        quo_q[s]  <= take ? (quo_in | (QS'(1) << (QS - 1 - s))) : quo_in;
        den_q[s]  <= den_in;
        age_q[s]  <= age_in;
        draw_q[s] <= draw_in;
        zmax_q[s] <= zmax_in;
      end
    end
  end

  // Final step: a zero lifetime gives the full step; undrawn particles give zero.
  logic [QS-1:0] step_full;
  logic [15:0]   step_ext;

  assign step_full = zmax_q[QS-1] ? QS'(GRADIENT_STEPS) : quo_q[QS-1];
  assign step_ext  = 16'(step_full);

  always_comb begin
    age_o.new_age       = age_q[QS-1];
    age_o.alive_out     = draw_q[QS-1];
    age_o.draw_now      = draw_q[QS-1];
    age_o.gradient_step = draw_q[QS-1] ? step_ext[6:0] : '0;
  end

  assign valid_o = dv_q[QS-1];

endmodule

### rtl/core/particle_euler_update.sv
// A start transfer runs through the kinematics pipeline and, beside it, the age divider with
// QS = max(2, clog2(GRADIENT_STEPS+1)) stages, one quotient bit a stage; both feed the output
// register, which raises result_valid_o together with the result.
// Throughput: one particle per cycle; busy_o stays low, since every stage advances each cycle.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset clears all valid bits and loads the configuration registers with their defaults.
module particle_euler_update #(
  parameter int unsigned GRADIENT_STEPS = pe_pkg::GRADIENT_STEPS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  pe_pkg::pe_in_t                in_i,
  output logic                          result_valid_o,
  output pe_pkg::pe_out_t               result_o,
  input  logic                          cfg_we_i,
  input  logic [pe_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pe_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned QW = $clog2(GRADIENT_STEPS + 1);
  localparam int unsigned QS = (QW < 2) ? 2 : QW;

  pe_pkg::pe_cfg_t cfg;
  pe_pkg::pe_kin_t kin;
  pe_pkg::pe_age_t age;
  logic            kin_valid, age_valid, accept;

  // Every stage moves on each cycle, so a new item is always welcome.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  pe_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  pe_kinematics #(
    .EXTRA (QS - 2)
  ) u_kin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .in_i    (in_i),
    .cfg_i   (cfg),
    .valid_o (kin_valid),
    .kin_o   (kin)
  );

  pe_age_div #(
    .GRADIENT_STEPS (GRADIENT_STEPS),
    .QS             (QS)
  ) u_age (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .in_i    (in_i),
    .cfg_i   (cfg),
    .valid_o (age_valid),
    .age_o   (age)
  );

  // Output register: both halves of the result arrive in the same cycle.
  logic            done_q, done_d;
  pe_pkg::pe_out_t res_q, res_d;

  assign done_d = kin_valid && age_valid;

  always_comb begin
    res_d.new_pos_x     = kin.new_pos_x;
    res_d.new_pos_y     = kin.new_pos_y;
    res_d.new_vel_x     = kin.new_vel_x;
    res_d.new_vel_y     = kin.new_vel_y;
    res_d.new_age       = age.new_age;
    res_d.pair_out      = kin.pair_out;
    res_d.alive_out     = age.alive_out;
    res_d.draw_now      = age.draw_now;
    res_d.gradient_step = age.gradient_step;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_d) begin
      res_q <= res_d;
    end
  end

  assign result_valid_o = done_q;
  assign result_o       = res_q;

endmodule

### rtl/core/pe_checker.sv
// Port-level checker for the particle Euler update, bound to the top level.
module pe_checker #(
  parameter int unsigned GRADIENT_STEPS = pe_pkg::GRADIENT_STEPS_DEF
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start_i,
  input logic            busy_o,
  input pe_pkg::pe_in_t  in_i,
  input logic            result_valid_o,
  input pe_pkg::pe_out_t result_o
);

  localparam int unsigned QW  = $clog2(GRADIENT_STEPS + 1);
  localparam int unsigned QS  = (QW < 2) ? 2 : QW;
  localparam int unsigned LAT = QS + 3;

  // A result transfer always goes back to a start transfer a fixed distance earlier.
  a_result_has_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i && !busy_o, LAT))
    else $error("result without a matching start transfer");

  // The color pair travels with its particle.
  a_pair_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> result_o.pair_out == $past(in_i.pair_in, LAT))
    else $error("color pair does not match its input");

  // A dead particle never comes back to life.
  a_no_revival: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.alive_out |-> $past(in_i.alive_in, LAT))
    else $error("inactive particle returned as active");

  // An inactive particle keeps its x position and is not drawn.
  a_inactive_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !$past(in_i.alive_in, LAT)
      |-> result_o.new_pos_x == $past(in_i.pos_x, LAT) && !result_o.draw_now)
    else $error("inactive particle was changed or drawn");

  // Only a drawn particle carries a gradient step.
  a_step_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.draw_now |-> result_o.gradient_step == '0)
    else $error("gradient step set on a particle that is not drawn");

endmodule

bind particle_euler_update pe_checker #(
  .GRADIENT_STEPS (GRADIENT_STEPS)
) u_pe_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .in_i           (in_i),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);

### test/particle_euler_update_tb.sv
// Self-checking testbench for particle_euler_update: directed particle table, then random records.
module particle_euler_update_tb;
  import pe_pkg::*;

  // Drain margin for the default 100 gradient steps, where QS = clog2(101) = 7.
  localparam int unsigned PIPE_LAT  = 9;
  localparam int unsigned STEPS     = GRADIENT_STEPS_DEF;
  localparam longint      AGE_MAX   = 64'h0000_0000_7FFF_FFFF;
  localparam longint      S32_MAX   = 64'sh0000_0000_7FFF_FFFF;
  localparam longint      S32_MIN   = -64'sh0000_0000_8000_0000;
  localparam int unsigned CYCLE_CAP = 500000;

  // One row of the directed table: the particle and, where typed in, its updated record.
  typedef struct packed {
    pe_in_t  item;
    logic    use_typed;
    pe_out_t want;
  } dir_row_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  logic                  busy;
  pe_in_t                in_item   = '0;
  logic                  res_valid;
  pe_out_t               res;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Side data that travels with the particle being offered.
  logic                  row_typed = 1'b0;
  pe_out_t               row_want  = '0;

  // Shadow of the block's configuration registers, kept in step with every write.
  pe_cfg_t cfg_shadow = '{friction_factor: FRICTION_RST, gravity_x: GRAVITY_X_RST,
                          gravity_y: GRAVITY_Y_RST, max_age: MAX_AGE_RST};

  pe_out_t     updates_due[$];
  dir_row_t    dir_tbl[$];
  pe_out_t     due;
  int unsigned err_cnt     = 0;
  int unsigned burst_left  = 0;
  int unsigned cycle_cnt   = 0;

  particle_euler_update u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_o         (busy),
    .in_i           (in_item),
    .result_valid_o (res_valid),
    .result_o       (res),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata)
  );

  // Clock with a period of two time units.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Clamp a wide signed value to the 32-bit signed range.
  function automatic longint clamp_s32(input longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  // Compute the updated particle record for one Euler step under the given configuration.
  function automatic pe_out_t predict_update(input pe_in_t it, input pe_cfg_t c);
    pe_out_t o;
    longint  vx, vy, px, py, fr, dt, age, ma;
    o.new_pos_x     = it.pos_x;
    o.new_pos_y     = it.pos_y;
    o.new_vel_x     = it.vel_x;
    o.new_vel_y     = it.vel_y;
    o.new_age       = it.age_in;
    o.pair_out      = it.pair_in;
    o.alive_out     = 1'b0;
    o.draw_now      = 1'b0;
    o.gradient_step = '0;
    if (it.alive_in) begin
      fr = longint'(c.friction_factor);
      dt = longint'(it.time_step);
      ma = longint'(c.max_age);
      // Velocity first, so that position advances with the new velocity.
      vx = clamp_s32(((longint'($signed(it.vel_x)) * fr) >>> 16)
                     + longint'($signed(c.gravity_x)));
      vy = clamp_s32(((longint'($signed(it.vel_y)) * fr) >>> 16)
                     + longint'($signed(c.gravity_y)));
      px = clamp_s32(longint'($signed(it.pos_x)) + ((vx * dt) >>> 16));
      py = clamp_s32(longint'($signed(it.pos_y)) + ((vy * dt) >>> 16));
      age = longint'(it.age_in) + dt;
      if (age > AGE_MAX) age = AGE_MAX;
      o.new_pos_x = px[31:0];
      o.new_pos_y = py[31:0];
      o.new_vel_x = vx[31:0];
      o.new_vel_y = vy[31:0];
      o.new_age   = age[30:0];
      // A particle survives while its age does not exceed the lifetime.
      if (age <= ma) begin
        o.alive_out = 1'b1;
        o.draw_now  = 1'b1;
        if (ma == 0) o.gradient_step = 7'(STEPS);
        else         o.gradient_step = 7'((longint'(STEPS) * age) / ma);
      end
    end
    return o;
  endfunction

  function automatic pe_in_t mk_in(input logic [31:0] px, input logic [31:0] py,
                                   input logic [31:0] vx, input logic [31:0] vy,
                                   input logic [30:0] age, input logic [3:0] pair,
                                   input logic alive, input logic [30:0] dt);
    pe_in_t it;
    it.pos_x     = px;
    it.pos_y     = py;
    it.vel_x     = vx;
    it.vel_y     = vy;
    it.age_in    = age;
    it.pair_in   = pair;
    it.alive_in  = alive;
    it.time_step = dt;
    return it;
  endfunction

  function automatic pe_out_t mk_out(input logic [31:0] px, input logic [31:0] py,
                                     input logic [31:0] vx, input logic [31:0] vy,
                                     input logic [30:0] age, input logic [3:0] pair,
                                     input logic alive, input logic draw,
                                     input logic [6:0] step);
    pe_out_t o;
    o.new_pos_x     = px;
    o.new_pos_y     = py;
    o.new_vel_x     = vx;
    o.new_vel_y     = vy;
    o.new_age       = age;
    o.pair_out      = pair;
    o.alive_out     = alive;
    o.draw_now      = draw;
    o.gradient_step = step;
    return o;
  endfunction

  // Append one row at the end of the directed table.
  task automatic add_row(input dir_row_t row);
    dir_tbl.insert(dir_tbl.size(), row);
  endtask

  // Random Q16.16 value: mostly full range or moderate magnitudes, at times small, sometimes an extreme.
  function automatic logic [31:0] rand_q16();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom;
    if (r < 8) return $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
    if (r < 9) return $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
    case ($urandom_range(0, 3))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // Random particle whose age is mostly scaled to the current lifetime.
  function automatic pe_in_t rand_item();
    pe_in_t      it;
    longint      ma, a;
    int unsigned r;
    ma = longint'(cfg_shadow.max_age);
    it.pos_x    = rand_q16();
    it.pos_y    = rand_q16();
    it.vel_x    = rand_q16();
    it.vel_y    = rand_q16();
    it.pair_in  = 4'($urandom_range(0, 15));
    it.alive_in = ($urandom_range(0, 99) < 88);
    r = $urandom_range(0, 19);
    if (r < 12) begin
      a = longint'($urandom_range(0, 32'(ma)));
    end else if (r < 15) begin
      a = ma + longint'($urandom_range(0, 64)) - 32;
    end else if (r < 18) begin
      a = longint'($urandom & 32'h7FFF_FFFF);
    end else begin
      a = (r == 18) ? 0 : AGE_MAX;
    end
    if (a < 0) a = 0;
    if (a > AGE_MAX) a = AGE_MAX;
    it.age_in = a[30:0];
    r = $urandom_range(0, 19);
    if (r < 10)      it.time_step = 31'($urandom_range(0, 32'h0002_0000));
    else if (r < 13) it.time_step = 31'($urandom_range(0, 32'(ma / 4)));
    else if (r < 17) it.time_step = 31'($urandom);
    else if (r < 18) it.time_step = '0;
    else if (r < 19) it.time_step = 31'h7FFF_FFFF;
    else             it.time_step = 31'($urandom_range(0, 15));
    return it;
  endfunction

  // Offer one particle after a random gap and wait for its transfer.
  task automatic send_item(input pe_in_t item, input logic use_typed, input pe_out_t want);
    int unsigned gap;
    int unsigned r;
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 2)       burst_left = $urandom_range(20, 80);
      else if (r < 45) gap = 0;
      else if (r < 80) gap = $urandom_range(1, 3);
      else if (r < 96) gap = $urandom_range(4, 12);
      else             gap = $urandom_range(13, 60);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    in_item   <= item;
    row_typed <= use_typed;
    row_want  <= want;
    do @(posedge clk); while (busy);
  endtask

  // Stop offering and wait until every updated record has come back and the pipeline is empty.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (updates_due.size() != 0);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  task automatic cfg_put(input cfg_idx_e idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Load all four registers while the block is idle.
  task automatic load_config(input logic [31:0] fr, input logic [31:0] gx,
                             input logic [31:0] gy, input logic [31:0] ma);
    drain();
    cfg_put(CFG_FRICTION, fr);
    cfg_put(CFG_GRAVITY_X, gx);
    cfg_put(CFG_GRAVITY_Y, gy);
    cfg_put(CFG_MAX_AGE, ma);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Stream random particles, now and then pausing until the block has drained.
  task automatic run_particles(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      send_item(rand_item(), 1'b0, '0);
      if ($urandom_range(0, 99) == 0) drain();
    end
  endtask

  // Track configuration writes, record each input transfer and check each result transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_idx_e'(cfg_idx))
          CFG_FRICTION:  cfg_shadow.friction_factor = cfg_wdata[30:0];
          CFG_GRAVITY_X: cfg_shadow.gravity_x       = cfg_wdata;
          CFG_GRAVITY_Y: cfg_shadow.gravity_y       = cfg_wdata;
          CFG_MAX_AGE:   cfg_shadow.max_age         = cfg_wdata[30:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        updates_due.insert(updates_due.size(),
                           row_typed ? row_want : predict_update(in_item, cfg_shadow));
      end
      if (res_valid) begin
        if (updates_due.size() == 0) begin
          if (err_cnt < 10) $display("ERROR: result transfer with no particle pending");
          err_cnt++;
        end else begin
          due = updates_due.pop_front();
          if (res.new_pos_x !== due.new_pos_x || res.new_pos_y !== due.new_pos_y ||
              res.new_vel_x !== due.new_vel_x || res.new_vel_y !== due.new_vel_y ||
              res.new_age !== due.new_age || res.pair_out !== due.pair_out ||
              res.alive_out !== due.alive_out || res.draw_now !== due.draw_now ||
              res.gradient_step !== due.gradient_step) begin
            if (err_cnt < 10) begin
              $display("ERROR: expected pos=%h,%h vel=%h,%h age=%h pair=%h alive=%b draw=%b step=%0d",
                       due.new_pos_x, due.new_pos_y, due.new_vel_x, due.new_vel_y,
                       due.new_age, due.pair_out, due.alive_out, due.draw_now,
                       due.gradient_step);
              $display("       actual   pos=%h,%h vel=%h,%h age=%h pair=%h alive=%b draw=%b step=%0d",
                       res.new_pos_x, res.new_pos_y, res.new_vel_x, res.new_vel_y,
                       res.new_age, res.pair_out, res.alive_out, res.draw_now,
                       res.gradient_step);
            end
            err_cnt++;
          end
        end
      end
    end
  end

  // Guard against a hung pipeline.
  initial begin
    while (cycle_cnt < CYCLE_CAP) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Main sequence: reset, directed table, then random phases over several configurations.
  initial begin
    // Rows with typed results assume the reset configuration: friction 1.0, gravity (0, -1.0),
    // lifetime 10.0.
    add_row('{mk_in(32'h1234_5678, 32'h8765_4321, 32'h7FFF_FFFF, 32'h8000_0000,
                    31'h7FFF_FFFF, 4'hF, 1'b0, 31'h7FFF_FFFF), 1'b1,
              mk_out(32'h1234_5678, 32'h8765_4321, 32'h7FFF_FFFF, 32'h8000_0000,
                     31'h7FFF_FFFF, 4'hF, 1'b0, 1'b0, 7'd0)});
    add_row('{mk_in(0, 0, 0, 0, 0, 4'h0, 1'b1, 0), 1'b1,
              mk_out(0, 0, 0, 32'hFFFF_0000, 0, 4'h0, 1'b1, 1'b1, 7'd0)});
    add_row('{mk_in(0, 0, 0, 0, 0, 4'h3, 1'b1, 31'd65536), 1'b1,
              mk_out(0, 32'hFFFF_0000, 0, 32'hFFFF_0000, 31'd65536, 4'h3,
                     1'b1, 1'b1, 7'd10)});
    // Age exactly at the lifetime still draws, with the full gradient step.
    add_row('{mk_in(0, 0, 0, 0, 31'd655360, 4'h5, 1'b1, 0), 1'b1,
              mk_out(0, 0, 0, 32'hFFFF_0000, 31'd655360, 4'h5, 1'b1, 1'b1, 7'd100)});
    // One unit past the lifetime: the particle dies but its motion is still updated.
    add_row('{mk_in(0, 0, 0, 0, 31'd655360, 4'h6, 1'b1, 31'd1), 1'b1,
              mk_out(0, 32'hFFFF_FFFF, 0, 32'hFFFF_0000, 31'd655361, 4'h6,
                     1'b0, 1'b0, 7'd0)});
    // Velocity stays at the top of its range and saturates at the bottom.
    add_row('{mk_in(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                    0, 4'hF, 1'b1, 0), 1'b1,
              mk_out(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                     0, 4'hF, 1'b1, 1'b1, 7'd0)});
    // Position saturates at both ends.
    add_row('{mk_in(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 0, 0, 4'h9,
                    1'b1, 31'd65536), 1'b1,
              mk_out(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'hFFFF_0000,
                     31'd65536, 4'h9, 1'b1, 1'b1, 7'd10)});
    // Age saturates at its maximum and the particle dies.
    add_row('{mk_in(0, 0, 0, 0, 31'h7FFF_FFFF, 4'h0, 1'b1, 31'h7FFF_FFFF), 1'b1,
              mk_out(0, 32'h8000_0001, 0, 32'hFFFF_0000, 31'h7FFF_FFFF, 4'h0,
                     1'b0, 1'b0, 7'd0)});
    add_row('{mk_in(0, 0, 0, 0, 31'd327680, 4'h1, 1'b1, 0), 1'b1,
              mk_out(0, 0, 0, 32'hFFFF_0000, 31'd327680, 4'h1, 1'b1, 1'b1, 7'd50)});
    // The remaining rows go through the predictor.
    add_row('{mk_in(0, 0, 32'hFFFF_FFFF, 32'hFFFF_8000, 0, 4'h2, 1'b1, 31'd1),
              1'b0, '0});
    add_row('{mk_in(32'h4000_0000, 32'hC000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                    31'd1000, 4'h7, 1'b1, 31'h0100_0000), 1'b0, '0});
    add_row('{mk_in(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    31'h5555_5555, 4'hA, 1'b1, 31'h2AAA_AAAA), 1'b0, '0});
    add_row('{mk_in(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                    31'h0000_5555, 4'h5, 1'b1, 31'h0000_AAAA), 1'b0, '0});
    add_row('{mk_in(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                    31'h2AAA_AAAA, 4'hA, 1'b0, 31'h5555_5555), 1'b0, '0});
    add_row('{mk_in(32'h0003_8000, 32'hFFFC_8000, 32'hFFFF_8000, 32'h0000_8000,
                    31'd655359, 4'hC, 1'b1, 31'd1), 1'b0, '0});
    add_row('{mk_in(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF,
                    31'd600000, 4'hE, 1'b1, 31'd32768), 1'b0, '0});

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table under the reset configuration.
    foreach (dir_tbl[i]) send_item(dir_tbl[i].item, dir_tbl[i].use_typed, dir_tbl[i].want);
    run_particles(100);

    // Extreme configurations, including a zero lifetime.
    load_config(32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
    run_particles(60);
    load_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    run_particles(60);
    load_config(32'h0001_0000, 32'h0000_0000, 32'hFFFF_0000, 32'h0000_0000);
    run_particles(30);

    // Random configurations, mostly physically sensible, sometimes arbitrary bits.
    for (int p = 0; p < 7; p++) begin
      load_config(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0002_0000),
                  ($urandom_range(0, 2) == 0) ? $urandom
                                              : $urandom_range(0, 32'h0004_0000) - 32'h0002_0000,
                  ($urandom_range(0, 2) == 0) ? $urandom
                                              : $urandom_range(0, 32'h0004_0000) - 32'h0002_0000,
                  ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 32'h0040_0000));
      run_particles(100);
    end

    drain();
    repeat (2 * PIPE_LAT) @(posedge clk);
    if (err_cnt == 0 && updates_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/pe_pkg.sv
rtl/core/pe_cfg_regs.sv
rtl/core/pe_kinematics.sv
rtl/core/pe_age_div.sv
rtl/core/particle_euler_update.sv
rtl/core/pe_checker.sv
test/particle_euler_update_tb.sv
